>>> sv/brfifo_pkg.sv
// shared types and constants for the byte ring fifo
`timescale 1ns / 1ps

package brfifo_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BYTES_DEF = 8;

	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int USED_W = 10;

	// byte lanes of a word and the storage banks behind them
	localparam int NBANK  = 8;
	localparam int BANK_W = 3;
	localparam int BYTE_W = 8;

	typedef enum logic [0:0] {
		CMD_WRITE = 1'b0,
		CMD_READ  = 1'b1
	} cmd_t;

endpackage

>>> sv/brfifo_in_if.sv
// request channel: command, length and bytes to write
`timescale 1ns / 1ps

interface brfifo_in_if import brfifo_pkg::*; ();

	logic                valid;
	logic                ready;
	cmd_t                cmd;
	logic [LEN_W-1:0]    length;
	logic [DATA_W-1:0]   write_bytes;

	modport source (output valid, output cmd, output length, output write_bytes, input ready);
	modport sink   (input valid, input cmd, input length, input write_bytes, output ready);

endinterface

>>> sv/brfifo_out_if.sv
// response channel: accept flag, bytes read and fill level
`timescale 1ns / 1ps

interface brfifo_out_if import brfifo_pkg::*; ();

	logic                valid;
	logic                ready;
	logic                accepted;
	logic [DATA_W-1:0]   read_bytes;
	logic [USED_W-1:0]   used_bytes;

	modport source (output valid, output accepted, output read_bytes, output used_bytes,
		input ready);
	modport sink   (input valid, input accepted, input read_bytes, input used_bytes,
		output ready);

endinterface

>>> sv/brfifo_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module brfifo_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/byte_ring_fifo_multibyte_unit.sv
// byte ring fifo with all-or-nothing multi-byte writes and reads
//
// Usage:
//   req carries one operation per word: cmd (write or read), length in bytes
//   (0 to MAX_BYTES) and, for writes, the bytes packed little-endian.
//   rsp returns one word per request: accepted, the bytes read (unused lanes
//   zero, all zero for writes and refused reads) and the fill level after the
//   operation, modulo 1024.
//   A write is refused when length >= free space, so one byte always stays
//   empty; a read is refused when fewer than length bytes are stored; a length
//   over MAX_BYTES is refused.
// Timing:
//   the accept edge updates the pointers and starts the bank reads; stage 1
//   moves into the response register once that register is free. One request
//   per cycle is taken as long as rsp drains.
//   Storage is eight byte-wide banks, one access per bank per cycle.
// Reset and stall:
//   reset empties the buffer (pointers and count to zero); stored bytes are not
//   cleared and need no clearing pass. When rsp stalls, the response holds;
//   a request in flight holds and drops req.ready. DEPTH must be a multiple of 8.
`timescale 1ns / 1ps

module byte_ring_fifo_multibyte_unit import brfifo_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	brfifo_in_if.sink     req,
	brfifo_out_if.source  rsp
);

	localparam int PW    = $clog2(DEPTH);
	localparam int ROWS  = DEPTH / NBANK;
	localparam int ROW_W = PW - BANK_W;

	// pointers and fill count
	logic [PW-1:0] wp_q, rp_q, used_q;

	// stage 1: decision made, bank reads in flight
	logic               valid_s1;
	logic               is_read_s1;
	logic               acc_s1;
	logic [USED_W-1:0]  used_s1;
	logic [BANK_W-1:0]  rot_s1;
	logic [LEN_W-1:0]   len_s1;

	// response register
	logic               out_valid_q;
	logic               out_acc_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [USED_W-1:0]  out_used_q;

	logic               fire, s1_free;
	logic               len_ok, wr_ok, rd_ok, op_ok;
	logic [PW:0]        len_x, used_x, ptr_sum, ptr_wrap, used_sum;
	logic [PW-1:0]      ptr, ptr_nxt, used_nxt;
	logic [PW+USED_W-1:0] used_ext;

	logic [BANK_W-1:0]  kb    [NBANK];
	logic [ROW_W-1:0]   row   [NBANK];
	logic               bank_we [NBANK];
	logic [BYTE_W-1:0]  bank_wd [NBANK];
	logic [BYTE_W-1:0]  bank_rd [NBANK];
	logic               bank_re;
	logic [DATA_W-1:0]  rd_word;

	assign s1_free   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || s1_free;
	assign fire      = req.valid && req.ready;

	always_comb begin
		len_x  = (PW+1)'(req.length);
		used_x = {1'b0, used_q};
		len_ok = req.length <= LEN_W'(MAX_BYTES);
		wr_ok  = len_ok && (req.cmd == CMD_WRITE) && ((used_x + len_x) < (PW+1)'(DEPTH));
		rd_ok  = len_ok && (req.cmd == CMD_READ) && (used_x >= len_x);
		op_ok  = wr_ok || rd_ok;

		ptr      = (req.cmd == CMD_WRITE) ? wp_q : rp_q;
		ptr_sum  = {1'b0, ptr} + len_x;
		ptr_wrap = (ptr_sum >= (PW+1)'(DEPTH)) ? ptr_sum - (PW+1)'(DEPTH) : ptr_sum;
		ptr_nxt  = ptr_wrap[PW-1:0];

		if (wr_ok) begin
			used_sum = used_x + len_x;
		end else if (rd_ok) begin
			used_sum = used_x - len_x;
		end else begin
			used_sum = used_x;
		end
		used_nxt = used_sum[PW-1:0];
		used_ext = (PW+USED_W)'(used_nxt);
		bank_re  = fire && rd_ok;
	end

	// bank b takes the byte at offset kb from the pointer
	always_comb begin
		logic [PW:0] pos, pos_w;
		pos   = '0;
		pos_w = '0;
		for (int b = 0; b < NBANK; b++) begin
			kb[b]      = BANK_W'(b) - ptr[BANK_W-1:0];
			pos        = {1'b0, ptr} + (PW+1)'(kb[b]);
			pos_w      = (pos >= (PW+1)'(DEPTH)) ? pos - (PW+1)'(DEPTH) : pos;
			row[b]     = pos_w[PW-1:BANK_W];
			bank_we[b] = fire && wr_ok && (LEN_W'(kb[b]) < req.length);
			bank_wd[b] = req.write_bytes[{kb[b], 3'b000} +: BYTE_W];
		end
	end

	for (genvar g = 0; g < NBANK; g++) begin : g_bank
		brfifo_ram #(
			.W     (BYTE_W),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.waddr (row[g]),
			.wdata (bank_wd[g]),
			.re    (bank_re),
			.raddr (row[g]),
			.rdata (bank_rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			used_q <= '0;
		end else if (fire) begin
			if (wr_ok) begin
				wp_q <= ptr_nxt;
			end
			if (rd_ok) begin
				rp_q <= ptr_nxt;
			end
			used_q <= used_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			is_read_s1 <= (req.cmd == CMD_READ);
			acc_s1     <= op_ok;
			used_s1    <= used_ext[USED_W-1:0];
			rot_s1     <= ptr[BANK_W-1:0];
			len_s1     <= req.length;
		end
	end

	// rotate bank outputs back into lane order and clear unused lanes
	always_comb begin
		logic [BANK_W-1:0] idx;
		idx     = '0;
		rd_word = '0;
		for (int k = 0; k < NBANK; k++) begin
			idx = rot_s1 + BANK_W'(k);
			if (is_read_s1 && acc_s1 && (LEN_W'(k) < len_s1)) begin
				rd_word[k*BYTE_W +: BYTE_W] = bank_rd[idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && valid_s1) begin
			out_acc_q  <= acc_s1;
			out_data_q <= rd_word;
			out_used_q <= used_s1;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.accepted   = out_acc_q;
	assign rsp.read_bytes = out_data_q;
	assign rsp.used_bytes = out_used_q;

	// fill count never reaches the full depth
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q != PW'(DEPTH - 1) || !(fire && wr_ok && req.length != '0))
		else $error("write accepted into a full buffer");

	// a refused operation never returns data
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.accepted |-> rsp.read_bytes == '0)
		else $error("refused operation returned data");

	// an oversize length is always refused
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (req.length > LEN_W'(MAX_BYTES)) |=> !acc_s1)
		else $error("oversize length accepted");

	// a write request, accepted or refused, never lowers the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.cmd == CMD_WRITE |=> used_q >= $past(used_q))
		else $error("write lowered the fill count");

endmodule

>>> bench/tb.sv
// self-checking bench for the byte ring fifo: directed table, then random fill and drain phases
`timescale 1ns / 1ps

module tb;
	import brfifo_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int RST_CYCLES = 9;
	localparam int RAND_WORDS = 1700;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_WAIT = 8;

	typedef struct packed {
		logic              acc;
		logic [DATA_W-1:0] rbytes;
		logic [USED_W-1:0] used;
	} rsp_word_t;

	// one directed request, with a hand-written response where fixed is set
	typedef struct packed {
		cmd_t              c;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] wb;
		logic              fixed;
		logic              w_acc;
		logic [DATA_W-1:0] w_rbytes;
		logic [USED_W-1:0] w_used;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	brfifo_in_if  req_if ();
	brfifo_out_if rsp_if ();

	byte_ring_fifo_multibyte_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #(CLK_HALF) clk = ~clk;

	// shadow copy of the ring
	logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
	int                rd_idx = 0;
	int                wr_idx = 0;

	rsp_word_t         pending_rsp [$];
	int                mismatch_cnt = 0;
	int                idle_cnt = 0;

	// words sent by the driver and responses seen by the monitor
	int                sent_cnt = 0;
	int                got_cnt = 0;

	// travels with the request word so the monitor knows which expectation to use
	logic              drv_fixed;
	rsp_word_t         drv_want;

	function automatic int fill_level();
		return (DEPTH_DEF + wr_idx - rd_idx) % DEPTH_DEF;
	endfunction

	function automatic rsp_word_t ring_step(input cmd_t c, input logic [LEN_W-1:0] l,
		input logic [DATA_W-1:0] w);
		rsp_word_t r;
		int        lvl;
		int        n;
		r   = '0;
		lvl = fill_level();
		n   = int'(l);
		if (n <= MAX_BYTES_DEF) begin
			if (c == CMD_WRITE) begin
				// one slot always stays empty
				if (n < DEPTH_DEF - lvl) begin
					for (int k = 0; k < n; k++)
						ring_mem[(wr_idx + k) % DEPTH_DEF] = w[BYTE_W*k +: BYTE_W];
					wr_idx = (wr_idx + n) % DEPTH_DEF;
					r.acc  = 1'b1;
				end
			end else begin
				if (lvl >= n) begin
					for (int k = 0; k < n; k++)
						r.rbytes[BYTE_W*k +: BYTE_W] = ring_mem[(rd_idx + k) % DEPTH_DEF];
					rd_idx = (rd_idx + n) % DEPTH_DEF;
					r.acc  = 1'b1;
				end
			end
		end
		r.used = USED_W'(fill_level());
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
		input logic [DATA_W-1:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	// response check first, then predict the request taken at the same edge
	always @(posedge clk) begin
		rsp_word_t want;
		rsp_word_t model;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got_cnt++;
				if (pending_rsp.size() == 0) begin
					flag_mismatch("response with nothing pending", DATA_W'(rsp_if.used_bytes),
						'0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_if.accepted !== want.acc)
						flag_mismatch("accepted", DATA_W'(rsp_if.accepted), DATA_W'(want.acc));
					if (rsp_if.read_bytes !== want.rbytes)
						flag_mismatch("read_bytes", rsp_if.read_bytes, want.rbytes);
					if (rsp_if.used_bytes !== want.used)
						flag_mismatch("used_bytes", DATA_W'(rsp_if.used_bytes),
							DATA_W'(want.used));
				end
			end
			if (req_if.valid && req_if.ready) begin
				model = ring_step(req_if.cmd, req_if.length, req_if.write_bytes);
				pending_rsp.push_back(drv_fixed ? drv_want : model);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: segments of always ready, coin flips, one in four, or rare stalls
	initial begin
		int seg_left;
		int seg_mode;
		int tick;
		seg_left = 0;
		seg_mode = 0;
		tick     = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 3);
				seg_left = $urandom_range(5, 60);
			end
			seg_left--;
			tick++;
			case (seg_mode)
				0: begin
					rsp_if.ready <= 1'b1;
				end
				1: begin
					rsp_if.ready <= 1'($urandom_range(0, 1));
				end
				2: begin
					rsp_if.ready <= (tick % 4 == 0);
				end
				default: begin
					rsp_if.ready <= ($urandom_range(0, 9) != 0);
				end
			endcase
		end
	end

	task automatic send_word(input cmd_t c, input logic [LEN_W-1:0] l,
		input logic [DATA_W-1:0] w, input logic fx, input rsp_word_t want);
		req_if.valid       <= 1'b1;
		req_if.cmd         <= c;
		req_if.length      <= l;
		req_if.write_bytes <= w;
		drv_fixed          <= fx;
		drv_want           <= want;
		do
			@(posedge clk);
		while (!req_if.ready);
		sent_cnt++;
	endtask

	task automatic hold_until_drained();
		req_if.valid <= 1'b0;
		while (got_cnt != sent_cnt)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		dir_row_t          plan [$];
		dir_row_t          row;
		rsp_word_t         want;
		cmd_t              c;
		logic [LEN_W-1:0]  l;
		logic [DATA_W-1:0] w;
		int                burst_left;
		int                gap;
		bit                filling;

		burst_left         = 0;
		filling            = 1'b1;
		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.cmd         = CMD_WRITE;
		req_if.length      = '0;
		req_if.write_bytes = '0;
		drv_fixed          = 1'b0;
		drv_want           = '0;

		// empty buffer, refused lengths, then one full word in and out
		plan.push_back('{CMD_READ,  4'd0,  64'd0, 1'b1, 1'b1, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd1,  64'd0, 1'b1, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd0,  64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'd0,
			10'd0});
		plan.push_back('{CMD_WRITE, 4'd15, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 64'd0,
			10'd0});
		plan.push_back('{CMD_READ,  4'd9,  64'd0, 1'b1, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd9,  64'hffff_ffff_ffff_ffff, 1'b1, 1'b0, 64'd0,
			10'd0});
		plan.push_back('{CMD_WRITE, 4'd8,  64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'd0,
			10'd8});
		plan.push_back('{CMD_READ,  4'd8,  64'd0, 1'b1, 1'b1, 64'hffff_ffff_ffff_ffff,
			10'd0});
		// rest goes through the predictor: lanes past length, partial reads, wrap of lanes
		plan.push_back('{CMD_WRITE, 4'd8,  64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd3,  64'hdead_beef_cafe_f00d, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd1,  64'hffff_ffff_ffff_ff5a, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd3,  64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd0,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd15, 64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd8,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd8,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd2,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd7,  64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_WRITE, 4'd12, 64'h5555_aaaa_5555_aaaa, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd8,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd9,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd8,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});
		plan.push_back('{CMD_READ,  4'd5,  64'd0, 1'b0, 1'b0, 64'd0, 10'd0});

		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row  = plan[i];
			want = '{row.w_acc, row.w_rbytes, row.w_used};
			send_word(row.c, row.len, row.wb, row.fixed, want);
		end
		hold_until_drained();

		// biased phases push the level to full and back to empty so both pointers wrap
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					req_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			if (n == RAND_WORDS / 2) begin
				hold_until_drained();
				burst_left = 0;
			end
			if (filling && fill_level() >= DEPTH_DEF - 2 && $urandom_range(0, 29) == 0)
				filling = 1'b0;
			else if (!filling && fill_level() == 0 && $urandom_range(0, 19) == 0)
				filling = 1'b1;
			if (filling)
				c = ($urandom_range(0, 99) < 85) ? CMD_WRITE : CMD_READ;
			else
				c = ($urandom_range(0, 99) < 15) ? CMD_WRITE : CMD_READ;
			if ($urandom_range(0, 9) == 0)
				l = LEN_W'($urandom_range(MAX_BYTES_DEF + 1, 15));
			else
				l = LEN_W'($urandom_range(0, MAX_BYTES_DEF));
			w = {$urandom, $urandom};
			send_word(c, l, w, 1'b0, '0);
		end

		req_if.valid <= 1'b0;
		while (got_cnt != sent_cnt)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> byte_ring_fifo_multibyte_unit.f
sv/brfifo_pkg.sv
sv/brfifo_in_if.sv
sv/brfifo_out_if.sv
sv/brfifo_ram.sv
sv/byte_ring_fifo_multibyte_unit.sv
bench/tb.sv
